// File: rtl/czs_pkg.sv
// Shared types and constants for the center zoom pixel scaler.
package czs_pkg;

  // Default geometry and fixed-point format
  localparam int WIDTH_DEF     = 320;
  localparam int HEIGHT_DEF    = 200;
  localparam int FRAC_BITS_DEF = 8;

  // Fixed field widths
  localparam int ACC_W   = 20;   // coordinate accumulator width, bit 19 is sign
  localparam int SCALE_W = 10;
  localparam int PIX_W   = 8;
  localparam int ADDR_IN_W = 16;

  // Step limits
  localparam int MIN_SCALE  = 32;
  localparam int RESET_STEP = 256;

  // Queue depths between front and back, and at the result side
  localparam int REQ_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FRAME = 2'd1,
    OP_PIXEL = 2'd2
  } op_t;

  // Control flags carried with each store request
  typedef struct packed {
    logic is_read;    // 1: screen pixel read, 0: source pixel write
    logic in_img;     // coordinates fall inside the source image
    logic row_end;
    logic frame_end;
  } req_ctl_t;

  localparam int REQ_CTL_W = $bits(req_ctl_t);

endpackage

// File: rtl/czs_fifo.sv
// Small register FIFO with push/full and pop/empty sides.
module czs_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] din,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output logic          empty,
  output logic [CW-1:0] count
);

  logic [DW-1:0] fifo_mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign dout    = fifo_mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo_mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: rtl/czs_front.sv
// Front end: accepts items, tracks the zoom raster and forms store requests.
module czs_front #(
  parameter int WIDTH     = czs_pkg::WIDTH_DEF,
  parameter int HEIGHT    = czs_pkg::HEIGHT_DEF,
  parameter int FRAC_BITS = czs_pkg::FRAC_BITS_DEF,
  localparam int AW       = $clog2(WIDTH * HEIGHT)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [1:0]                          in_op,
  input  logic [czs_pkg::ADDR_IN_W-1:0]       in_address,
  input  logic [czs_pkg::PIX_W-1:0]           in_pixel_in,
  input  logic [czs_pkg::SCALE_W-1:0]         in_scale,
  output logic                                q_push,
  input  logic                                q_full,
  output czs_pkg::req_ctl_t                   q_ctl,
  output logic [AW-1:0]                       q_addr,
  output logic [czs_pkg::PIX_W-1:0]           q_data
);
  import czs_pkg::*;

  localparam int XW     = $clog2(WIDTH);
  localparam int YW     = $clog2(HEIGHT);
  localparam int HALF_W = WIDTH / 2;
  localparam int HALF_H = HEIGHT / 2;
  localparam int DEPTH  = WIDTH * HEIGHT;
  localparam logic [ACC_W-1:0] CTR_U = ACC_W'(HALF_W << FRAC_BITS);
  localparam logic [ACC_W-1:0] CTR_V = ACC_W'(HALF_H << FRAC_BITS);
  localparam logic [ACC_W-1:0] V_CORNER_RST =
    ACC_W'((HALF_H << FRAC_BITS) - RESET_STEP * HALF_H);

  // Raster state
  logic [SCALE_W-1:0] step_r, step_nxt;
  logic [ACC_W-1:0]   row_u_r, row_u_nxt;
  logic [ACC_W-1:0]   u_r, u_nxt;
  logic [ACC_W-1:0]   v_r, v_nxt;
  logic [ACC_W-1:0]   v_corner_r, v_corner_nxt;
  logic [XW-1:0]      col_r, col_nxt;
  logic [YW-1:0]      row_r, row_nxt;

  // Request stage
  logic               a_valid_r, a_valid_nxt;
  req_ctl_t           a_ctl_r, a_ctl_nxt;
  logic [XW-1:0]      a_sx_r;
  logic [YW-1:0]      a_sy_r;
  logic [AW-1:0]      a_addr_r;
  logic [PIX_W-1:0]   a_data_r;

  logic               a_ready, accept, ld_ok, u_in, v_in, last_col, last_row;
  logic [SCALE_W-1:0] step_new;
  logic [ACC_W-1:0]   corner_u, corner_v;
  logic [31:0]        ux, vy;

  assign a_ready = !a_valid_r || !q_full;
  assign in_full = !a_ready;
  assign accept  = in_push && a_ready;

  // Frame start: clamped step and corner coordinates
  assign step_new = (in_scale < SCALE_W'(MIN_SCALE)) ? SCALE_W'(MIN_SCALE) : in_scale;
  assign corner_u = CTR_U - ACC_W'(step_new) * ACC_W'(HALF_W);
  assign corner_v = CTR_V - ACC_W'(step_new) * ACC_W'(HALF_H);

  // Integer coordinates and bounds
  assign ux       = 32'(u_r[ACC_W-1:FRAC_BITS]);
  assign vy       = 32'(v_r[ACC_W-1:FRAC_BITS]);
  assign u_in     = !u_r[ACC_W-1] && (ux < 32'(WIDTH));
  assign v_in     = !v_r[ACC_W-1] && (vy < 32'(HEIGHT));
  assign last_col = (col_r == XW'(WIDTH - 1));
  assign last_row = (row_r == YW'(HEIGHT - 1));
  assign ld_ok    = (32'(in_address) < 32'(DEPTH));

  // Next state for raster and request stage
  always_comb begin
    step_nxt     = step_r;
    row_u_nxt    = row_u_r;
    u_nxt        = u_r;
    v_nxt        = v_r;
    v_corner_nxt = v_corner_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    a_valid_nxt  = a_ready ? 1'b0 : a_valid_r;
    a_ctl_nxt    = '0;
    if (accept) begin
      unique case (in_op)
        OP_LOAD: begin
          a_valid_nxt = ld_ok;
        end
        OP_FRAME: begin
          step_nxt     = step_new;
          row_u_nxt    = corner_u;
          u_nxt        = corner_u;
          v_nxt        = corner_v;
          v_corner_nxt = corner_v;
          col_nxt      = '0;
          row_nxt      = '0;
        end
        OP_PIXEL: begin
          a_valid_nxt       = 1'b1;
          a_ctl_nxt.is_read = 1'b1;
          a_ctl_nxt.in_img  = u_in && v_in;
          if (last_col) begin
            a_ctl_nxt.row_end = 1'b1;
            col_nxt           = '0;
            u_nxt             = row_u_r;
            if (last_row) begin
              a_ctl_nxt.frame_end = 1'b1;
              row_nxt             = '0;
              v_nxt               = v_corner_r;
            end else begin
              row_nxt = row_r + 1'b1;
              v_nxt   = v_r + ACC_W'(step_r);
            end
          end else begin
            col_nxt = col_r + 1'b1;
            u_nxt   = u_r + ACC_W'(step_r);
          end
        end
        default: begin
          a_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= SCALE_W'(RESET_STEP);
      row_u_r    <= '0;
      u_r        <= '0;
      v_r        <= '0;
      v_corner_r <= V_CORNER_RST;
      col_r      <= '0;
      row_r      <= '0;
      a_valid_r  <= 1'b0;
    end else begin
      step_r     <= step_nxt;
      row_u_r    <= row_u_nxt;
      u_r        <= u_nxt;
      v_r        <= v_nxt;
      v_corner_r <= v_corner_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      a_valid_r  <= a_valid_nxt;
    end
  end

  // Request payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      a_ctl_r  <= a_ctl_nxt;
      a_sx_r   <= XW'(ux);
      a_sy_r   <= YW'(vy);
      a_addr_r <= AW'(in_address);
      a_data_r <= in_pixel_in;
    end
  end

  // Store address: row times width plus column for reads
  assign q_push = a_valid_r;
  assign q_ctl  = a_ctl_r;
  assign q_data = a_data_r;
  assign q_addr = a_ctl_r.is_read ? AW'(AW'(a_sy_r) * AW'(WIDTH)) + AW'(a_sx_r)
                                  : a_addr_r;

endmodule

// File: rtl/czs_back.sv
// Back end: image store access and result queue.
module czs_back #(
  parameter int WIDTH  = czs_pkg::WIDTH_DEF,
  parameter int HEIGHT = czs_pkg::HEIGHT_DEF,
  localparam int AW    = $clog2(WIDTH * HEIGHT)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  czs_pkg::req_ctl_t         q_ctl,
  input  logic [AW-1:0]             q_addr,
  input  logic [czs_pkg::PIX_W-1:0] q_data,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [czs_pkg::PIX_W-1:0] out_pixel_out,
  output logic                      out_row_end,
  output logic                      out_frame_end
);
  import czs_pkg::*;

  localparam int DEPTH = WIDTH * HEIGHT;
  localparam int OW    = PIX_W + 2;
  localparam int OCW   = $clog2(OUT_DEPTH + 1);

  logic [PIX_W-1:0] store_mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;
  logic             m_valid_r, m_valid_nxt;
  req_ctl_t         m_ctl_r;
  logic [OCW-1:0]   o_count;
  logic             credit, wr_en, rd_en;
  logic [OW-1:0]    o_din, o_dout;

  // Reads need room in the result queue, counting the one in flight
  assign credit = (32'(o_count) + 32'(m_valid_r)) < 32'(OUT_DEPTH);
  assign q_pop  = !q_empty && (!q_ctl.is_read || credit);
  assign wr_en  = q_pop && !q_ctl.is_read;
  assign rd_en  = q_pop && q_ctl.is_read;
  assign m_valid_nxt = rd_en;

  // Single-port image store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[q_addr] <= q_data;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= m_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      m_ctl_r <= q_ctl;
    end
  end

  // Outside the image the pixel reads as zero
  assign o_din = {(m_ctl_r.in_img ? rd_data_r : '0), m_ctl_r.row_end, m_ctl_r.frame_end};

  czs_fifo #(
    .DW    (OW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (m_valid_r),
    .din   (o_din),
    .full  (),
    .pop   (out_pop),
    .dout  (o_dout),
    .empty (out_empty),
    .count (o_count)
  );

  assign out_pixel_out = o_dout[OW-1:2];
  assign out_row_end   = o_dout[1];
  assign out_frame_end = o_dout[0];

endmodule

// File: rtl/center_zoom_pixel_scaler.sv
// A next-pixel item passes the front request register, request queue, registered store read
// and result queue to the result ports. Throughput: one item per cycle while the request
// queue has room; each in-range load or next-pixel item makes one pass through the store.
// Load and frame-start items give no result. Synchronous reset (rst_n low) resets the raster,
// step, queues and valid flags; the image store is not cleared, entries defined once loaded.
module center_zoom_pixel_scaler #(
  parameter int WIDTH     = czs_pkg::WIDTH_DEF,
  parameter int HEIGHT    = czs_pkg::HEIGHT_DEF,
  parameter int FRAC_BITS = czs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [1:0]                    in_op,
  input  logic [czs_pkg::ADDR_IN_W-1:0] in_address,
  input  logic [czs_pkg::PIX_W-1:0]     in_pixel_in,
  input  logic [czs_pkg::SCALE_W-1:0]   in_scale,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [czs_pkg::PIX_W-1:0]     out_pixel_out,
  output logic                          out_row_end,
  output logic                          out_frame_end
);
  import czs_pkg::*;

  localparam int AW = $clog2(WIDTH * HEIGHT);
  localparam int QW = REQ_CTL_W + AW + PIX_W;

  logic             f_push, f_full, b_empty, b_pop;
  req_ctl_t         f_ctl, b_ctl;
  logic [AW-1:0]    f_addr, b_addr;
  logic [PIX_W-1:0] f_data, b_data;
  logic [QW-1:0]    q_din, q_dout;

  // Front end: raster tracking and request forming
  czs_front #(
    .WIDTH     (WIDTH),
    .HEIGHT    (HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_op       (in_op),
    .in_address  (in_address),
    .in_pixel_in (in_pixel_in),
    .in_scale    (in_scale),
    .q_push      (f_push),
    .q_full      (f_full),
    .q_ctl       (f_ctl),
    .q_addr      (f_addr),
    .q_data      (f_data)
  );

  // Request queue between front and back
  assign q_din = {f_ctl, f_addr, f_data};

  czs_fifo #(
    .DW    (QW),
    .DEPTH (REQ_DEPTH)
  ) u_req_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (q_din),
    .full  (f_full),
    .pop   (b_pop),
    .dout  (q_dout),
    .empty (b_empty),
    .count ()
  );

  assign b_ctl  = req_ctl_t'(q_dout[QW-1:AW+PIX_W]);
  assign b_addr = q_dout[AW+PIX_W-1:PIX_W];
  assign b_data = q_dout[PIX_W-1:0];

  // Back end: store access and results
  czs_back #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (b_empty),
    .q_pop         (b_pop),
    .q_ctl         (b_ctl),
    .q_addr        (b_addr),
    .q_data        (b_data),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_pixel_out (out_pixel_out),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

endmodule

// File: rtl/czs_checker.sv
// Port-level checks for the center zoom pixel scaler, bound to the top level.
module czs_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_full,
  input logic                      out_empty,
  input logic                      out_pop,
  input logic [czs_pkg::PIX_W-1:0] out_pixel_out,
  input logic                      out_row_end,
  input logic                      out_frame_end
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result waiting after reset");

  // Reset leaves the input side open
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // The last pixel of a frame is also the last of its row
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_end) |-> out_row_end)
    else $error("frame end without row end");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_pixel_out) && $stable(out_row_end)
       && $stable(out_frame_end)))
    else $error("waiting result changed before pop");

endmodule

bind center_zoom_pixel_scaler czs_checker u_czs_checker (.*);
